// ----- design/fbtc_pkg.sv -----
// Shared types, constants and character mapping for the base-90 float text codec.
`default_nettype none
package fbtc_pkg;

	localparam int NSTG = 7;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [30:0] BIG_MAG   = 31'h6E013F39;
	localparam logic [30:0] SMALL_MAG = 31'h10FD87B6;

	localparam logic [6:0] ZERO_DIGIT  = 7'd80;
	localparam logic [6:0] SIGN_OFFSET = 7'd40;
	localparam logic [6:0] HIGH_STRIDE = 7'd12;
	localparam logic [6:0] RADIX       = 7'd90;
	localparam logic [7:0] CHAR_BASE   = 8'd33;

	localparam logic [19:0] RADIX3 = 20'd729000;
	localparam logic [12:0] RADIX2 = 13'd8100;

	localparam logic [23:0] RECIP3 = 24'd12065971;
	localparam logic [20:0] RECIP2 = 21'd1060485;
	localparam logic [12:0] RECIP1 = 13'd5825;

	typedef struct packed {
		logic        opcode;
		logic [31:0] float_in;
		logic [39:0] code_in;
	} cmd_t;

	typedef struct packed {
		logic [39:0] code_out;
		logic [31:0] float_out;
		logic        was_clamped;
		logic        code_invalid;
	} rsp_t;

	typedef struct packed {
		logic       ok;
		logic [6:0] digit;
	} digit_t;

	function automatic logic [7:0] digit_to_char(input logic [6:0] d);
		logic [7:0] c;
		c = {1'b0, d} + CHAR_BASE;
		if (c > 8'd94) begin
			c = c + 8'd1;
		end
		if (c > 8'd123) begin
			c = c + 8'd1;
		end
		return c;
	endfunction

	function automatic digit_t char_to_digit(input logic [7:0] c);
		logic [7:0] d;
		digit_t     r;
		d = c;
		if (d >= 8'd124) begin
			d = d - 8'd1;
		end
		if (d >= 8'd95) begin
			d = d - 8'd1;
		end
		r.ok    = (d >= CHAR_BASE) && (d <= 8'd122);
		r.digit = 7'(d - CHAR_BASE);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/float_base90_text_codec.sv -----
// Top level of the base-90 float text codec: handshake control and result select.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one beat per conversion:
//   opcode selects encode of float_in or decode of code_in.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one beat per command, in order.
//   Encode fills code_out and was_clamped; decode fills float_out and code_invalid;
//   the unused fields of a beat are zero.
// Timing:
//   A command passes to its response beat through the seven register stages of the
//   datapath (the encode digit split by reciprocal multiply and correction takes six
//   of them). One beat per cycle is sustained while rsp_stall holds no waiting response.
// Reset:
//   arst_n clears all stage valid bits; the pipeline comes up empty with no response.
// Backpressure:
//   While rsp_stall holds a waiting response, empty stages behind it still fill;
//   cmd_stall rises only once every stage holds a beat. Nothing is dropped or repeated.
`default_nettype none
module float_base90_text_codec
	import fbtc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] op_q;
	logic [NSTG-1:0] adv;
	logic [39:0]     enc_code;
	logic            enc_clamped;
	logic [31:0]     dec_value;
	logic            dec_invalid;

	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || !rsp_stall;
		for (int i = NSTG - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= cmd_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			op_q[0] <= cmd.opcode;
		end
		for (int i = 1; i < NSTG; i++) begin
			if (adv[i]) begin
				op_q[i] <= op_q[i-1];
			end
		end
	end

	fbtc_enc u_enc (
		.clk      (clk),
		.adv      (adv),
		.float_in (cmd.float_in),
		.code     (enc_code),
		.clamped  (enc_clamped)
	);

	fbtc_dec u_dec (
		.clk     (clk),
		.adv     (adv),
		.code_in (cmd.code_in),
		.value   (dec_value),
		.invalid (dec_invalid)
	);

	assign cmd_stall = !adv[0];
	assign rsp_valid = vld_q[NSTG-1];

	always_comb begin
		rsp = '0;
		if (op_q[NSTG-1] == OP_DECODE) begin
			rsp.float_out    = dec_value;
			rsp.code_invalid = dec_invalid;
		end else begin
			rsp.code_out    = enc_code;
			rsp.was_clamped = enc_clamped;
		end
	end

endmodule
`default_nettype wire

// ----- design/fbtc_enc.sv -----
// Encode datapath: float bit pattern to five base-90 characters over seven stages.
`default_nettype none
module fbtc_enc
	import fbtc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic [NSTG-1:0] adv,
	input  wire logic [31:0]     float_in,
	output logic [39:0]          code,
	output logic                 clamped
);

	typedef struct packed {
		logic       sign;
		logic       zero;
		logic       clamp;
		logic [1:0] hi;
		logic [6:0] d3;
	} enc_side_t;

	enc_side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [22:0] mant_s1, mant_s2;
	logic [3:0]  q4_s2, d4_s3, d4_s4, d4_s5, d4_s6, d4_s7;
	logic [19:0] r1_s3, r1_s4;
	logic [6:0]  q2_s4, d2_s5, d2_s6, d2_s7;
	logic [12:0] r2_s5, r2_s6;
	logic [6:0]  q1_s6, d1_s7, d0_s7;

	enc_side_t   side_c;
	logic [30:0] mag_c;
	logic [7:0]  lx_c;
	logic [46:0] p4_c;
	logic [23:0] r3_c;
	logic [40:0] p2_c;
	logic [19:0] r2w_c;
	logic [25:0] p1_c;
	logic [12:0] r1w_c;
	logic [6:0]  d4f_c;

	always_comb begin
		side_c.sign  = float_in[31];
		mag_c        = float_in[30:0];
		side_c.zero  = (mag_c == 31'd0);
		side_c.clamp = 1'b0;
		if (!side_c.zero && (mag_c > BIG_MAG)) begin
			mag_c        = BIG_MAG;
			side_c.clamp = 1'b1;
		end else if (!side_c.zero && (mag_c < SMALL_MAG)) begin
			mag_c        = SMALL_MAG;
			side_c.clamp = 1'b1;
		end
		lx_c = mag_c[30:23] + 8'd2;
		if (lx_c >= 8'd180) begin
			side_c.hi = 2'd2;
			side_c.d3 = 7'(lx_c - 8'd180);
		end else if (lx_c >= 8'd90) begin
			side_c.hi = 2'd1;
			side_c.d3 = 7'(lx_c - 8'd90);
		end else begin
			side_c.hi = 2'd0;
			side_c.d3 = 7'(lx_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s1 <= side_c;
			mant_s1 <= mag_c[22:0];
		end
	end

	assign p4_c = {24'd0, mant_s1} * {23'd0, RECIP3};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			side_s2 <= side_s1;
			mant_s2 <= mant_s1;
			q4_s2   <= p4_c[46:43];
		end
	end

	assign r3_c = {1'b0, mant_s2} - ({20'd0, q4_s2} * {4'd0, RADIX3});

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s3 <= side_s2;
			if (r3_c >= {4'd0, RADIX3}) begin
				d4_s3 <= q4_s2 + 4'd1;
				r1_s3 <= 20'(r3_c - {4'd0, RADIX3});
			end else begin
				d4_s3 <= q4_s2;
				r1_s3 <= 20'(r3_c);
			end
		end
	end

	assign p2_c = {21'd0, r1_s3} * {20'd0, RECIP2};

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			side_s4 <= side_s3;
			d4_s4   <= d4_s3;
			r1_s4   <= r1_s3;
			q2_s4   <= p2_c[39:33];
		end
	end

	assign r2w_c = r1_s4 - ({13'd0, q2_s4} * {7'd0, RADIX2});

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			side_s5 <= side_s4;
			d4_s5   <= d4_s4;
			if (r2w_c >= {7'd0, RADIX2}) begin
				d2_s5 <= q2_s4 + 7'd1;
				r2_s5 <= 13'(r2w_c - {7'd0, RADIX2});
			end else begin
				d2_s5 <= q2_s4;
				r2_s5 <= 13'(r2w_c);
			end
		end
	end

	assign p1_c = {13'd0, r2_s5} * {13'd0, RECIP1};

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			side_s6 <= side_s5;
			d4_s6   <= d4_s5;
			d2_s6   <= d2_s5;
			r2_s6   <= r2_s5;
			q1_s6   <= p1_c[25:19];
		end
	end

	assign r1w_c = r2_s6 - ({6'd0, q1_s6} * {6'd0, RADIX});

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			side_s7 <= side_s6;
			d4_s7   <= d4_s6;
			d2_s7   <= d2_s6;
			if (r1w_c >= {6'd0, RADIX}) begin
				d1_s7 <= q1_s6 + 7'd1;
				d0_s7 <= 7'(r1w_c - {6'd0, RADIX});
			end else begin
				d1_s7 <= q1_s6;
				d0_s7 <= 7'(r1w_c);
			end
		end
	end

	always_comb begin
		d4f_c = {3'd0, d4_s7} + ({5'd0, side_s7.hi} * HIGH_STRIDE)
			+ (side_s7.sign ? SIGN_OFFSET : 7'd0);
		if (side_s7.zero) begin
			code = {digit_to_char(ZERO_DIGIT), digit_to_char(7'd0), digit_to_char(7'd0),
				digit_to_char(7'd0), digit_to_char(7'd0)};
		end else begin
			code = {digit_to_char(d4f_c), digit_to_char(side_s7.d3), digit_to_char(d2_s7),
				digit_to_char(d1_s7), digit_to_char(d0_s7)};
		end
		clamped = side_s7.clamp;
	end

endmodule
`default_nettype wire

// ----- design/fbtc_dec.sv -----
// Decode datapath: five base-90 characters to a float bit pattern over seven stages.
`default_nettype none
module fbtc_dec
	import fbtc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic [NSTG-1:0] adv,
	input  wire logic [39:0]     code_in,
	output logic [31:0]          value,
	output logic                 invalid
);

	typedef struct packed {
		logic zero;
		logic bad;
		logic sign;
	} dec_side_t;

	dec_side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [2:0]        hi_s1;
	logic [3:0]        tr_s1;
	logic [6:0]        d3_s1, d2_s1, d1_s1, d0_s1;
	logic [23:0]       mhi_s2;
	logic [12:0]       mlo_s2;
	logic signed [9:0] e_s2, e_s3;
	logic [23:0]       mant_s3;
	logic [31:0]       val_s4, val_s5, val_s6, val_s7;

	digit_t      dg0_c, dg1_c, dg2_c, dg3_c, dg4_c;
	dec_side_t   side_c;
	logic [6:0]  t_c;
	logic [2:0]  hi_c;
	logic [3:0]  tr_c;
	logic [23:0] sig_c;
	logic [23:0] q_c;
	logic [2:0]  rem_c;
	logic [2:0]  half_c;
	logic [9:0]  shw_c;
	logic [31:0] val_c;
	dec_side_t   side4_c;

	always_comb begin
		dg0_c = char_to_digit(code_in[7:0]);
		dg1_c = char_to_digit(code_in[15:8]);
		dg2_c = char_to_digit(code_in[23:16]);
		dg3_c = char_to_digit(code_in[31:24]);
		dg4_c = char_to_digit(code_in[39:32]);
		side_c.zero = dg4_c.ok && (dg4_c.digit == ZERO_DIGIT);
		side_c.bad  = !(dg0_c.ok && dg1_c.ok && dg2_c.ok && dg3_c.ok && dg4_c.ok);
		side_c.sign = (dg4_c.digit >= SIGN_OFFSET);
		t_c = side_c.sign ? (dg4_c.digit - SIGN_OFFSET) : dg4_c.digit;
		if (t_c >= 7'd48) begin
			hi_c = 3'd4;
			tr_c = 4'(t_c - 7'd48);
		end else if (t_c >= 7'd36) begin
			hi_c = 3'd3;
			tr_c = 4'(t_c - 7'd36);
		end else if (t_c >= 7'd24) begin
			hi_c = 3'd2;
			tr_c = 4'(t_c - 7'd24);
		end else if (t_c >= HIGH_STRIDE) begin
			hi_c = 3'd1;
			tr_c = 4'(t_c - HIGH_STRIDE);
		end else begin
			hi_c = 3'd0;
			tr_c = 4'(t_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s1 <= side_c;
			hi_s1   <= hi_c;
			tr_s1   <= tr_c;
			d3_s1   <= dg3_c.digit;
			d2_s1   <= dg2_c.digit;
			d1_s1   <= dg1_c.digit;
			d0_s1   <= dg0_c.digit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			side_s2 <= side_s1;
			mhi_s2  <= ({20'd0, tr_s1} * {4'd0, RADIX3}) + ({17'd0, d2_s1} * {11'd0, RADIX2});
			mlo_s2  <= ({6'd0, d1_s1} * {6'd0, RADIX}) + {6'd0, d0_s1};
			e_s2    <= $signed(({7'd0, hi_s1} * {3'd0, RADIX}) + {3'd0, d3_s1}) - 10'sd2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s3 <= side_s2;
			e_s3    <= e_s2;
			mant_s3 <= mhi_s2 + {11'd0, mlo_s2};
		end
	end

	always_comb begin
		side4_c     = side_s3;
		side4_c.bad = side_s3.bad || mant_s3[23];
		sig_c       = {1'b1, mant_s3[22:0]};
		shw_c       = 10'(10'sd1 - e_s3);
		case (shw_c[1:0])
			2'd1: begin
				q_c    = {1'b0, sig_c[23:1]};
				rem_c  = {2'd0, sig_c[0]};
				half_c = 3'd1;
			end
			2'd2: begin
				q_c    = {2'd0, sig_c[23:2]};
				rem_c  = {1'd0, sig_c[1:0]};
				half_c = 3'd2;
			end
			default: begin
				q_c    = {3'd0, sig_c[23:3]};
				rem_c  = sig_c[2:0];
				half_c = 3'd4;
			end
		endcase
		if ((rem_c > half_c) || ((rem_c == half_c) && q_c[0])) begin
			q_c = q_c + 24'd1;
		end
		if (side_s3.zero || side4_c.bad) begin
			val_c = 32'd0;
		end else if (e_s3 >= 10'sd255) begin
			val_c = {side_s3.sign, 8'hFF, 23'd0};
		end else if (e_s3 >= 10'sd1) begin
			val_c = {side_s3.sign, e_s3[7:0], mant_s3[22:0]};
		end else begin
			val_c = {side_s3.sign, 7'd0, q_c};
		end
		side4_c.bad = side4_c.bad && !side_s3.zero;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			side_s4 <= side4_c;
			val_s4  <= val_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			side_s5 <= side_s4;
			val_s5  <= val_s4;
		end
		if (adv[5]) begin
			side_s6 <= side_s5;
			val_s6  <= val_s5;
		end
		if (adv[6]) begin
			side_s7 <= side_s6;
			val_s7  <= val_s6;
		end
	end

	assign value   = val_s7;
	assign invalid = side_s7.bad;

endmodule
`default_nettype wire
